@@ rtl/vzd_pkg.sv @@
package vzd_pkg;

    // func codes
    localparam logic [1:0] FUNC_UNSIGNED = 2'd0;
    localparam logic [1:0] FUNC_SIGNED   = 2'd1;
    localparam logic [1:0] FUNC_SKIP     = 2'd2;
    localparam logic [1:0] FUNC_RAW      = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_OVFL  = 2'd2;

    localparam int GROUP_BITS = 7;
    localparam int CONT_BIT   = 7;
    localparam logic [3:0] MAX_GROUPS = 4'd10;
    localparam logic [3:0] COUNT_SAT  = 4'd11;

    typedef struct packed {
        logic [7:0] byte_in;
        logic [1:0] func;
        logic       buffer_end;
    } in_beat_t;

    typedef struct packed {
        logic        [63:0] uvalue;
        logic signed [63:0] svalue;
        logic        [3:0]  byte_count;
        logic        [1:0]  error;
    } out_beat_t;

endpackage

@@ rtl/varint_zigzag_decoder.sv @@
// m_valid rises once the byte completing a result has passed the input register and then
// the result register, with the group shift-or between them; a low m_ready can stall it.
// Throughput: one byte per cycle unless a low m_ready holds a full result register.
// Reset (aresetn, synchronous, active low) empties both registers and clears the
// accumulator, group count and overflow flag.
module varint_zigzag_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vzd_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vzd_pkg::out_beat_t  m_data
);

    logic               in_valid_reg;
    vzd_pkg::in_beat_t  in_data_reg;
    logic               out_valid_reg;
    vzd_pkg::out_beat_t out_data_reg;

    logic               advance;
    logic               step;
    logic               emit;
    vzd_pkg::out_beat_t result;

    // The result register moves whenever it is empty or being drained; the input register
    // takes a new beat whenever it is empty or its content moves on in the same cycle.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step    = in_valid_reg && advance;

    vzd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .beat    (in_data_reg),
        .emit    (emit),
        .result  (result)
    );

    // Control: valid flags of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                // a skipped varint or a continuation byte leaves the slot empty
                out_valid_reg <= step && emit;
            end
        end
    end

    // Payload: hold unless a new beat lands.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step && emit) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled while the pipeline has room");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error != vzd_pkg::ERR_NONE
            |-> m_data.uvalue == 64'd0 && m_data.svalue == 64'sd0)
        else $error("error beat carries a value");

    a_ovfl_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error == vzd_pkg::ERR_OVFL
            |-> m_data.byte_count == vzd_pkg::COUNT_SAT)
        else $error("overflow beat with short byte count");

endmodule

@@ rtl/vzd_core.sv @@
module vzd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  vzd_pkg::in_beat_t    beat,
    output logic                 emit,
    output vzd_pkg::out_beat_t   result
);

    logic [63:0] acc_reg, acc_next;
    logic [3:0]  gc_reg, gc_next;
    logic        ovf_reg, ovf_next;

    logic        in_range;
    logic [5:0]  shamt;
    logic [63:0] shifted;
    logic [63:0] acc_add;
    logic [3:0]  gc_add;
    logic        ovf_add;
    logic        is_last;
    logic        is_raw;

    assign in_range = (gc_reg < vzd_pkg::MAX_GROUPS);
    // only read while in range, where the shift stays below 64
    assign shamt    = 6'(gc_reg) * 6'(vzd_pkg::GROUP_BITS);
    // bits of the tenth group above bit 63 fall off the top
    assign shifted  = {57'd0, beat.byte_in[6:0]} << shamt;
    assign acc_add  = in_range ? (acc_reg | shifted) : acc_reg;
    assign ovf_add  = ovf_reg | !in_range;
    assign gc_add   = (gc_reg < vzd_pkg::COUNT_SAT) ? gc_reg + 4'd1 : gc_reg;
    assign is_last  = !beat.byte_in[vzd_pkg::CONT_BIT];
    assign is_raw   = (beat.func == vzd_pkg::FUNC_RAW);

    always_comb begin
        emit              = 1'b0;
        result.uvalue     = '0;
        result.svalue     = '0;
        result.byte_count = gc_add;
        result.error      = vzd_pkg::ERR_NONE;
        acc_next          = acc_add;
        gc_next           = gc_add;
        ovf_next          = ovf_add;
        if (is_raw) begin
            // pass the byte through, drop any partial varint
            emit              = 1'b1;
            result.uvalue     = {56'd0, beat.byte_in};
            result.byte_count = 4'd1;
            acc_next          = '0;
            gc_next           = '0;
            ovf_next          = 1'b0;
        end else if (is_last) begin
            acc_next = '0;
            gc_next  = '0;
            ovf_next = 1'b0;
            if (ovf_add) begin
                emit         = 1'b1;
                result.error = vzd_pkg::ERR_OVFL;
            end else begin
                emit          = (beat.func != vzd_pkg::FUNC_SKIP);
                result.uvalue = acc_add;
                result.svalue = $signed((acc_add >> 1) ^ {64{acc_add[0]}});
            end
        end else if (beat.buffer_end) begin
            emit         = 1'b1;
            result.error = ovf_add ? vzd_pkg::ERR_OVFL : vzd_pkg::ERR_TRUNC;
            acc_next     = '0;
            gc_next      = '0;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            gc_reg  <= '0;
            ovf_reg <= 1'b0;
        end else if (step) begin
            acc_reg <= acc_next;
            gc_reg  <= gc_next;
            ovf_reg <= ovf_next;
        end
    end

    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> gc_reg == vzd_pkg::COUNT_SAT)
        else $error("overflow flag set without saturated group count");

    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        gc_reg == 4'd0 |-> acc_reg == 64'd0)
        else $error("accumulator not clear at varint start");

endmodule
